FILE: design/tach_pkg.sv
// Shared types and constants for the slew-limited pulse-count tachometer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tach_pkg;

  localparam int TOT_W  = 32;
  localparam int RPM_W  = 16;
  localparam int PROD_W = 48;
  localparam int WIN_W  = 16;
  localparam int STEP_W = 8;
  localparam int CFG_W  = 16;

  localparam logic [RPM_W-1:0]  MS_PER_MINUTE = 16'd60000;
  localparam logic [WIN_W-1:0]  WINDOW_MS_RST = 16'd1000;
  localparam logic [STEP_W-1:0] MAX_STEP_RST  = 8'd50;
  localparam logic [RPM_W-1:0]  RPM_MAX       = 16'hFFFF;
  localparam logic [TOT_W-1:0]  TOTAL_MAX     = 32'hFFFF_FFFF;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_WINDOW_MS = 1'b0;
  localparam cfg_idx_t CFG_MAX_STEP  = 1'b1;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW    = $clog2(JOBQ_DEPTH + 1);

  localparam int DIV_STEPS = RPM_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [TOT_W-1:0] pulse_total;
    logic [TOT_W-1:0] time_total;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_CHK,
    BK_DIV,
    BK_SLEW
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/tach_front.sv
// Front end: accepts updates, keeps the saturating totals, closes windows.
// Depends on tach_pkg; feeds closed windows to tach_jobq.
`default_nettype none

module tach_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          accept,
  input  wire  [tach_pkg::RPM_W-1:0]   pulses,
  input  wire  [tach_pkg::RPM_W-1:0]   elapsed_ms,
  input  wire  [tach_pkg::WIN_W-1:0]   window_ms,
  output logic                         q_push,
  output tach_pkg::job_t               job
);
  import tach_pkg::*;

  logic [TOT_W-1:0] pulse_total_r, pulse_total_nxt;
  logic [TOT_W-1:0] time_total_r, time_total_nxt;
  logic [TOT_W:0]   psum, tsum;
  logic [TOT_W-1:0] psat, tsat;
  logic [WIN_W-1:0] win;
  logic             close;

  always_comb begin
    psum  = {1'b0, pulse_total_r} + {{(TOT_W+1-RPM_W){1'b0}}, pulses};
    tsum  = {1'b0, time_total_r} + {{(TOT_W+1-RPM_W){1'b0}}, elapsed_ms};
    psat  = psum[TOT_W] ? TOTAL_MAX : psum[TOT_W-1:0];
    tsat  = tsum[TOT_W] ? TOTAL_MAX : tsum[TOT_W-1:0];
    win   = (window_ms == '0) ? WIN_W'(1) : window_ms;
    close = tsat >= {{(TOT_W-WIN_W){1'b0}}, win};
    q_push = accept && close;
    job.pulse_total = psat;
    job.time_total  = tsat;
    pulse_total_nxt = pulse_total_r;
    time_total_nxt  = time_total_r;
    if (accept) begin
      pulse_total_nxt = close ? '0 : psat;
      time_total_nxt  = close ? '0 : tsat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_total_r <= '0;
      time_total_r  <= '0;
    end else begin
      pulse_total_r <= pulse_total_nxt;
      time_total_r  <= time_total_nxt;
    end
  end

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> (pulse_total_r == '0) && (time_total_r == '0))
    else $error("totals not cleared after window close");

  a_push_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> job.time_total != '0)
    else $error("closed window with zero time total");

endmodule

`default_nettype wire

FILE: design/tach_jobq.sv
// Short queue of closed windows between front and back end.
// Depends on tach_pkg.
`default_nettype none

module tach_jobq (
  input  wire                clk,
  input  wire                rst_n,
  input  tach_pkg::q_ctrl_t  ctrl,
  input  tach_pkg::job_t     wr_job,
  output tach_pkg::job_t     rd_job,
  output tach_pkg::q_stat_t  stat
);
  import tach_pkg::*;

  job_t               slot_r [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOBQ_CW-1:0] count_r;
  logic               do_push, do_pop;

  always_comb begin
    stat.full  = count_r == JOBQ_CW'(JOBQ_DEPTH);
    stat.empty = count_r == '0;
    do_push    = ctrl.push && !stat.full;
    do_pop     = ctrl.pop && !stat.empty;
    rd_job     = slot_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= JOBQ_CW'(JOBQ_DEPTH))
    else $error("job queue count out of range");

endmodule

`default_nettype wire

FILE: design/tach_back.sv
// Back end: rpm from a closed window by multiply and serial division,
// slew limiting and the result register. Depends on tach_pkg.
`default_nettype none

module tach_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tach_pkg::job_t               job,
  input  tach_pkg::q_stat_t            q_stat,
  output logic                         q_pop,
  input  wire  [tach_pkg::STEP_W-1:0]  max_step,
  input  wire                          out_pop,
  output logic                         out_valid,
  output logic [tach_pkg::RPM_W-1:0]   out_display,
  output logic [tach_pkg::RPM_W-1:0]   out_measured
);
  import tach_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [TOT_W-1:0]  pulse_r, div_r, rem_r, rem_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [RPM_W-1:0]  quo_r, quo_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic [RPM_W-1:0]  shown_r, slew;
  logic [RPM_W-1:0]  out_display_r, out_measured_r;
  logic              out_valid_r;
  logic [TOT_W:0]    trial;
  logic              ge;
  logic [RPM_W-1:0]  diff;
  logic [RPM_W:0]    up;
  logic [RPM_W-1:0]  stepx;
  logic              out_free;

  always_comb begin
    trial   = {rem_r, quo_r[RPM_W-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? TOT_W'(trial - {1'b0, div_r}) : trial[TOT_W-1:0];
    quo_nxt = {quo_r[RPM_W-2:0], ge};

    stepx = {{(RPM_W-STEP_W){1'b0}}, max_step};
    diff  = (quo_r >= shown_r) ? quo_r - shown_r : shown_r - quo_r;
    up    = {1'b0, shown_r} + {1'b0, stepx};
    if (diff >= stepx) begin
      if (shown_r >= quo_r) begin
        slew = (shown_r > stepx) ? shown_r - stepx : '0;
      end else begin
        slew = up[RPM_W] ? RPM_MAX : up[RPM_W-1:0];
      end
    end else begin
      slew = quo_r;
    end
    out_free = !out_valid_r || out_pop;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: state_nxt = BK_CHK;
      BK_CHK: state_nxt = (prod_r[PROD_W-1:RPM_W] >= div_r) ? BK_SLEW : BK_DIV;
      BK_DIV: begin
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          state_nxt = BK_SLEW;
        end
      end
      BK_SLEW: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        pulse_r <= job.pulse_total;
        div_r   <= job.time_total;
      end
      BK_MUL: prod_r <= PROD_W'(pulse_r) * PROD_W'(MS_PER_MINUTE);
      BK_CHK: begin
        rem_r <= prod_r[PROD_W-1:RPM_W];
        quo_r <= (prod_r[PROD_W-1:RPM_W] >= div_r) ? RPM_MAX : prod_r[RPM_W-1:0];
        cnt_r <= '0;
      end
      BK_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == BK_SLEW && out_free) begin
        shown_r        <= slew;
        out_valid_r    <= 1'b1;
        out_display_r  <= slew;
        out_measured_r <= quo_r;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_display  = out_display_r;
  assign out_measured = out_measured_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> rem_r < div_r)
    else $error("partial remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MUL || state_r == BK_CHK || state_r == BK_DIV) |-> div_r != '0)
    else $error("zero divisor in back end");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SLEW && out_free) |=> out_valid_r && (out_display_r == shown_r))
    else $error("result register does not match shown rpm");

endmodule

`default_nettype wire

FILE: design/tachometer_rpm_slew_limited.sv
// Pulse-count tachometer with slew-limited display rpm, top level.
// Holds the configuration registers; instantiates tach_front, tach_jobq, tach_back.
//
// Input channel (in_push / in_full): one update of pulse count and elapsed
// milliseconds per transfer; an update may be transferred every cycle while
// in_full is low. Updates that do not close a window give no result.
// Result channel (out_empty / out_pop): one result per closed window, with
// the slew-limited display rpm and the saturated measured rpm.
// A closed window passes through a two-entry queue to the back end, which
// handles it in order: the pop, one multiply, a range check, a 16-step
// restoring division and the slew step (no division when the rpm saturates).
// The back end pops a new window only after the slew step of the last one,
// so the serial divider works on one window at a time.
// When out_pop stays low, the result register holds, the back end waits,
// the queue fills and in_full rises.
// Synchronous active-low reset clears totals, shown rpm and queue, and loads
// window_ms 1000 and max_step 50. Write configuration only while idle.
`default_nettype none

module tachometer_rpm_slew_limited (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_push,
  output logic                         in_full,
  input  wire  [tach_pkg::RPM_W-1:0]   in_pulses,
  input  wire  [tach_pkg::RPM_W-1:0]   in_elapsed_ms,
  output logic                         out_empty,
  input  wire                          out_pop,
  output logic [tach_pkg::RPM_W-1:0]   out_display_rpm,
  output logic [tach_pkg::RPM_W-1:0]   out_measured_rpm,
  input  wire                          cfg_we,
  input  tach_pkg::cfg_idx_t           cfg_index,
  input  wire  [tach_pkg::CFG_W-1:0]   cfg_wdata
);
  import tach_pkg::*;

  logic [WIN_W-1:0]  window_ms_r;
  logic [STEP_W-1:0] max_step_r;
  logic              accept;
  logic              out_valid;
  q_ctrl_t           q_ctrl;
  q_stat_t           q_stat;
  job_t              wr_job, rd_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_ms_r <= WINDOW_MS_RST;
      max_step_r  <= MAX_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_MS: window_ms_r <= cfg_wdata[WIN_W-1:0];
        CFG_MAX_STEP:  max_step_r  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_full   = q_stat.full;
  assign accept    = in_push && !q_stat.full;
  assign out_empty = !out_valid;

  tach_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pulses     (in_pulses),
    .elapsed_ms (in_elapsed_ms),
    .window_ms  (window_ms_r),
    .q_push     (q_ctrl.push),
    .job        (wr_job)
  );

  tach_jobq u_jobq (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (q_ctrl),
    .wr_job (wr_job),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  tach_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job          (rd_job),
    .q_stat       (q_stat),
    .q_pop        (q_ctrl.pop),
    .max_step     (max_step_r),
    .out_pop      (out_pop),
    .out_valid    (out_valid),
    .out_display  (out_display_rpm),
    .out_measured (out_measured_rpm)
  );

endmodule

`default_nettype wire

FILE: sim/tb_tachometer_rpm_slew_limited.sv
// Self-checking testbench for tachometer_rpm_slew_limited: queued updates are
// driven with random gaps and every result is checked against a local rpm model.
// Depends on tach_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_tachometer_rpm_slew_limited;
  import tach_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAMP_ITEMS     = 260;
  localparam int MIX_PHASES     = 4;
  localparam int MIX_ITEMS      = 68;

  typedef struct packed {
    logic [RPM_W-1:0] pulses;
    logic [RPM_W-1:0] elapsed;
  } update_t;

  typedef struct packed {
    logic [RPM_W-1:0] display;
    logic [RPM_W-1:0] measured;
  } rpm_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [RPM_W-1:0]  in_pulses = '0;
  logic [RPM_W-1:0]  in_elapsed_ms = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [RPM_W-1:0]  out_display_rpm;
  logic [RPM_W-1:0]  out_measured_rpm;
  logic              cfg_we = 1'b0;
  cfg_idx_t          cfg_index = CFG_WINDOW_MS;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  update_t           update_q[$];
  rpm_result_t       rpm_expected_q[$];
  update_t           drive_upd;
  rpm_result_t       seen_rpm;

  logic [WIN_W-1:0]  win_len = WINDOW_MS_RST;
  logic [STEP_W-1:0] slew_step = MAX_STEP_RST;
  logic [TOT_W-1:0]  pulse_acc = '0;
  logic [TOT_W-1:0]  time_acc = '0;
  logic [RPM_W-1:0]  disp_rpm = '0;

  bit                calm = 1'b0;
  int unsigned       in_gap = 0;
  int unsigned       pop_gap = 0;
  int unsigned       quiet_cycles = 0;
  int                errors = 0;

  tachometer_rpm_slew_limited u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_pulses        (in_pulses),
    .in_elapsed_ms    (in_elapsed_ms),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_display_rpm  (out_display_rpm),
    .out_measured_rpm (out_measured_rpm),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Add one update to the totals; close the window and slew the display when due.
  function automatic void absorb_update(logic [RPM_W-1:0] p, logic [RPM_W-1:0] e);
    logic [TOT_W:0]   psum;
    logic [TOT_W:0]   tsum;
    logic [WIN_W-1:0] win;
    logic [63:0]      quot;
    logic [RPM_W-1:0] tgt;
    logic [RPM_W-1:0] delta;
    logic [RPM_W:0]   up;
    rpm_result_t      res;
    psum = {1'b0, pulse_acc} + p;
    tsum = {1'b0, time_acc} + e;
    pulse_acc = psum[TOT_W] ? TOTAL_MAX : psum[TOT_W-1:0];
    time_acc = tsum[TOT_W] ? TOTAL_MAX : tsum[TOT_W-1:0];
    win = (win_len == '0) ? WIN_W'(1) : win_len;
    if (time_acc < TOT_W'(win)) return;
    quot = (64'(pulse_acc) * 64'(MS_PER_MINUTE)) / 64'(time_acc);
    tgt = (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];
    pulse_acc = '0;
    time_acc = '0;
    delta = (tgt >= disp_rpm) ? tgt - disp_rpm : disp_rpm - tgt;
    if (delta >= RPM_W'(slew_step)) begin
      if (disp_rpm >= tgt) begin
        disp_rpm = (disp_rpm > RPM_W'(slew_step)) ? disp_rpm - RPM_W'(slew_step) : '0;
      end else begin
        up = {1'b0, disp_rpm} + (RPM_W + 1)'(slew_step);
        disp_rpm = up[RPM_W] ? RPM_MAX : up[RPM_W-1:0];
      end
    end else begin
      disp_rpm = tgt;
    end
    res.display = disp_rpm;
    res.measured = tgt;
    rpm_expected_q.push_back(res);
  endfunction

  function automatic update_t mix_update(logic [WIN_W-1:0] w);
    update_t     u;
    int unsigned r;
    int unsigned span;
    span = (w == '0) ? 2 : w / 3 + 1;
    r = $urandom_range(0, 99);
    if (r < 80) u.elapsed = RPM_W'($urandom_range(0, span));
    else if (r < 88) u.elapsed = '0;
    else u.elapsed = RPM_W'($urandom());
    r = $urandom_range(0, 99);
    if (r < 20) u.pulses = RPM_W'($urandom());
    else if (r < 28) u.pulses = '0;
    else if (r < 33) u.pulses = RPM_MAX;
    else u.pulses = RPM_W'($urandom_range(0, 32'(u.elapsed) + 2));
    return u;
  endfunction

  task automatic add_update(int unsigned p, int unsigned e);
    update_q.push_back('{pulses: RPM_W'(p), elapsed: RPM_W'(e)});
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (update_q.size() != 0 || in_push || rpm_expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_WINDOW_MS) win_len = val[WIN_W-1:0];
    else slew_step = val[STEP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drain, let the last window-less updates settle, then load both registers.
  task automatic reconfigure(int unsigned win, int unsigned step);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_WINDOW_MS, CFG_W'(win));
    write_reg(CFG_MAX_STEP, {8'($urandom()), STEP_W'(step)});
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_push && !in_full) absorb_update(in_pulses, in_elapsed_ms);
      if (!(in_push && in_full)) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_push <= 1'b0;
        end else if (update_q.size() != 0) begin
          drive_upd = update_q.pop_front();
          in_push <= 1'b1;
          in_pulses <= drive_upd.pulses;
          in_elapsed_ms <= drive_upd.elapsed;
          in_gap <= pick_gap();
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (rpm_expected_q.size() == 0) begin
          $error("unexpected result: display_rpm %0d, measured_rpm %0d",
                 out_display_rpm, out_measured_rpm);
          errors++;
        end else begin
          seen_rpm = rpm_expected_q.pop_front();
          if (out_display_rpm !== seen_rpm.display) begin
            $error("display_rpm: expected %0d, got %0d", seen_rpm.display, out_display_rpm);
            errors++;
          end
          if (out_measured_rpm !== seen_rpm.measured) begin
            $error("measured_rpm: expected %0d, got %0d", seen_rpm.measured, out_measured_rpm);
            errors++;
          end
        end
      end
      if (pop_gap != 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (out_pop && !out_empty) pop_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[tachometer_rpm_slew_limited] ERROR");
      $finish;
    end
  end

  initial begin
    update_t u;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration: empty and full-scale fields, saturated rate, slew up
    add_update(0, 0);
    add_update(65535, 0);
    add_update(0, 65535);
    add_update(65535, 999);
    add_update(1, 1);
    add_update(300, 1000);
    add_update(16'hAAAA, 16'h5555);
    add_update(16'h5555, 16'hAAAA);

    // zero window acts as one millisecond; zero step freezes the display
    reconfigure(0, 0);
    add_update(10, 0);
    add_update(5, 1);
    add_update(0, 1);

    // widest window: product beyond 32 bits, slew down by a full step
    reconfigure(65535, 255);
    add_update(60000, 65534);
    add_update(60000, 65535);
    add_update(0, 65535);
    add_update(1, 65535);

    reconfigure(1, 1);
    add_update(1, 60000);
    add_update(2, 60000);
    add_update(0, 1);

    // zero window with the largest step, updates back to back
    reconfigure(0, 255);
    calm = 1'b1;
    add_update(1, 0);
    add_update(0, 1);

    // drive the display up to full scale, one step per window
    reconfigure(1, 255);
    calm = 1'b0;
    repeat (RAMP_ITEMS) add_update($urandom_range(30000, 65535), $urandom_range(1, 3));

    for (int ph = 0; ph < MIX_PHASES; ph++) begin
      case (ph)
        0: reconfigure(65535, 1);
        1: reconfigure($urandom_range(1, 300), $urandom_range(0, 255));
        2: reconfigure($urandom_range(300, 20000), $urandom_range(1, 254));
        default: reconfigure(0, 255);
      endcase
      calm = ph[0];
      repeat (MIX_ITEMS) begin
        u = mix_update(win_len);
        update_q.push_back(u);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[tachometer_rpm_slew_limited] OK");
    end else begin
      $display("[tachometer_rpm_slew_limited] ERROR");
    end
    $finish;
  end

endmodule
